/* rtl/pwd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwd_pkg
// Shared widths and defaults for the pairwise distance stream.
// ----------------------------------------------------------------------------
package pwd_pkg;

  localparam int MaxPointsDef = 8;

  localparam int CoordW = 24;               // signed Q12.12 coordinate
  localparam int PointW = 3 * CoordW;       // stored point {z, y, x}
  localparam int MagW   = CoordW;           // |a - b| fits in 24 bits
  localparam int SqW    = 2 * MagW;         // one squared difference
  localparam int SumW   = SqW + 2;          // sum of three squares
  localparam int DistW  = SumW / 2;         // floor of the square root
  localparam int IdxW   = 3;                // reported point index

  localparam int SqrtSteps = SumW / 2;
  localparam int StepW     = $clog2(SqrtSteps);
  localparam int RemW      = DistW + 3;

  localparam int InDataW  = 72;
  localparam int OutDataW = 32;

endpackage

/* rtl/pwd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pwd_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/pwd_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwd_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pwd_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pwd_pkg::SumW-1:0]   radicand,
  output logic                       done,
  output logic [pwd_pkg::DistW-1:0]  root
);

  logic [pwd_pkg::SumW-1:0]  rad;
  logic [pwd_pkg::RemW-1:0]  rem;
  logic [pwd_pkg::StepW-1:0] cnt;
  logic                      busy;

  logic [pwd_pkg::RemW-1:0]  rem_sh;
  logic [pwd_pkg::RemW-1:0]  trial;
  logic                      ge;

  // bring in the next two radicand bits, try root*4+1
  assign rem_sh = {rem[pwd_pkg::RemW-3:0], rad[pwd_pkg::SumW-1 -: 2]};
  assign trial  = pwd_pkg::RemW'({root, 2'b01});
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= pwd_pkg::StepW'(pwd_pkg::SqrtSteps - 1);
      end else if (busy) begin
        rad  <= {rad[pwd_pkg::SumW-3:0], 2'b00};
        rem  <= ge ? (rem_sh - trial) : rem_sh;
        root <= {root[pwd_pkg::DistW-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/pairwise_distance_stream.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_distance_stream
// Euclidean distance from each arriving 3-D point to every earlier point.
// ----------------------------------------------------------------------------
// Input channel s_*: one point per item, x/y/z in signed Q12.12, s_tuser set
// on the first point of a set. Each point that fits is written to the RAM; then
// the block reads back the earlier points of the set, oldest first, and
// sends one item per pair on m_*: floored distance (Q13.12), new and old
// index, m_tlast on the final pair of that point. The first point of a set
// gives no output. A point arriving on a full store is dropped and answered
// by one item with m_tuser (overflow) and m_tlast set.
// s_tready is high only while no point is in work; each distance runs through
// RAM read, difference, square, sum, the bit-serial square root including its
// done step, and output load, so a point with n earlier points holds the input
// until all n distances are loaded. The square root unit sets the pace.
// The output register decouples the sides; if m_tready stays low, the next
// distance waits at the output load step and the block holds.
// Reset clears the point count and the output valid; stored points are
// not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module pairwise_distance_stream #(
  parameter int MAX_POINTS = pwd_pkg::MaxPointsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // coord_x [23:0], coord_y [47:24], coord_z [71:48]
  input  logic [pwd_pkg::InDataW-1:0]   s_tdata,
  // first_point [0]
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // distance [24:0], new_index [27:25], old_index [30:28], zero [31]
  output logic [pwd_pkg::OutDataW-1:0]  m_tdata,
  // last_in_run
  output logic                          m_tlast,
  // overflow [0]
  output logic                          m_tuser
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [6:0] {
    IDLE = 7'b0000001,
    RD   = 7'b0000010,
    DIF  = 7'b0000100,
    MUL  = 7'b0001000,
    SUM  = 7'b0010000,
    ROOT = 7'b0100000,
    PUSH = 7'b1000000
  } state_t;

  state_t state;

  logic [CW-1:0] count;
  logic [AW-1:0] n;
  logic [AW-1:0] j;
  logic          ovf;

  logic signed [pwd_pkg::CoordW-1:0] px, py, pz;
  logic [pwd_pkg::MagW-1:0]          mx, my, mz;
  logic [pwd_pkg::SqW-1:0]           sqx, sqy, sqz;
  logic [pwd_pkg::DistW-1:0]         pair_dist;

  logic                              out_valid;
  logic [pwd_pkg::DistW-1:0]         out_dist;
  logic [pwd_pkg::IdxW-1:0]          out_new;
  logic [pwd_pkg::IdxW-1:0]          out_old;
  logic                              out_last;
  logic                              out_ovf;

  logic                              accept;
  logic                              full;
  logic [AW-1:0]                     n_in;
  logic                              ram_we;
  logic [pwd_pkg::PointW-1:0]        rdata;
  logic [pwd_pkg::SumW-1:0]          sum;
  logic                              sq_done;
  logic [pwd_pkg::DistW-1:0]         sq_root;
  logic                              last_pair;
  logic                              out_free;
  logic                              push;

  logic signed [pwd_pkg::CoordW:0]   dx, dy, dz;
  logic [pwd_pkg::MagW-1:0]          ax, ay, az;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign full     = !s_tuser && (count == CW'(MAX_POINTS));
  assign n_in     = s_tuser ? '0 : count[AW-1:0];
  assign ram_we   = accept && !full;

  pwd_ram #(
    .Width (pwd_pkg::PointW),
    .Depth (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (n_in),
    .wdata (s_tdata[pwd_pkg::PointW-1:0]),
    .re    (state == RD),
    .raddr (j),
    .rdata (rdata)
  );

  // differences against the stored point, magnitude only
  always_comb begin
    dx = {px[pwd_pkg::CoordW-1], px}
       - {rdata[pwd_pkg::CoordW-1], rdata[pwd_pkg::CoordW-1:0]};
    dy = {py[pwd_pkg::CoordW-1], py}
       - {rdata[2*pwd_pkg::CoordW-1], rdata[2*pwd_pkg::CoordW-1:pwd_pkg::CoordW]};
    dz = {pz[pwd_pkg::CoordW-1], pz}
       - {rdata[3*pwd_pkg::CoordW-1], rdata[3*pwd_pkg::CoordW-1:2*pwd_pkg::CoordW]};
    ax = dx[pwd_pkg::CoordW] ? pwd_pkg::MagW'(-dx) : pwd_pkg::MagW'(dx);
    ay = dy[pwd_pkg::CoordW] ? pwd_pkg::MagW'(-dy) : pwd_pkg::MagW'(dy);
    az = dz[pwd_pkg::CoordW] ? pwd_pkg::MagW'(-dz) : pwd_pkg::MagW'(dz);
  end

  assign sum = pwd_pkg::SumW'(sqx) + pwd_pkg::SumW'(sqy) + pwd_pkg::SumW'(sqz);

  pwd_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == SUM),
    .radicand (sum),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign last_pair = ((j + AW'(1)) == n);
  assign out_free  = !out_valid || m_tready;
  assign push      = (state == PUSH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // load a new item, or drop the one just taken
      out_valid <= push || (out_valid && !m_tready);
      unique case (state)
        IDLE: begin
          if (accept) begin
            if (full) begin
              ovf   <= 1'b1;
              state <= PUSH;
            end else begin
              ovf   <= 1'b0;
              n     <= n_in;
              j     <= '0;
              count <= CW'(n_in) + CW'(1);
              px    <= s_tdata[pwd_pkg::CoordW-1:0];
              py    <= s_tdata[2*pwd_pkg::CoordW-1:pwd_pkg::CoordW];
              pz    <= s_tdata[3*pwd_pkg::CoordW-1:2*pwd_pkg::CoordW];
              // the first point of a set has nothing to compare against
              state <= (n_in == '0) ? IDLE : RD;
            end
          end
        end
        RD: begin
          state <= DIF;
        end
        DIF: begin
          mx    <= ax;
          my    <= ay;
          mz    <= az;
          state <= MUL;
        end
        MUL: begin
          sqx   <= mx * mx;
          sqy   <= my * my;
          sqz   <= mz * mz;
          state <= SUM;
        end
        SUM: begin
          state <= ROOT;
        end
        ROOT: begin
          if (sq_done) begin
            pair_dist <= sq_root;
            state     <= PUSH;
          end
        end
        PUSH: begin
          if (out_free) begin
            if (ovf) begin
              out_dist <= '0;
              out_new  <= '0;
              out_old  <= '0;
              out_last <= 1'b1;
              out_ovf  <= 1'b1;
              state    <= IDLE;
            end else begin
              out_dist <= pair_dist;
              out_new  <= pwd_pkg::IdxW'(n);
              out_old  <= pwd_pkg::IdxW'(j);
              out_last <= last_pair;
              out_ovf  <= 1'b0;
              if (last_pair) begin
                state <= IDLE;
              end else begin
                j     <= j + AW'(1);
                state <= RD;
              end
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_old, out_new, out_dist};
  assign m_tlast  = out_last;
  assign m_tuser  = out_ovf;

endmodule

/* test/pairwise_distance_stream_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_distance_stream_test
// Self-checking bench for the pairwise 3-D distance stream.
// ----------------------------------------------------------------------------
// Points go in as signed Q12.12 triples on the s_* stream. A local point store
// works out the floored distances to the earlier points of the set, plus the
// overflow answer when the store is full. Each item on m_* is checked field by
// field against the oldest pending distance. A short directed table covers
// extreme coordinates, a full store, and a first flag on a full store. Random
// point sets of varied size follow, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module pairwise_distance_stream_test;

  localparam int StoreDepth = pwd_pkg::MaxPointsDef;
  localparam int PointItems = 480;
  localparam int CycleLimit = 1000000;
  localparam int LongHold   = 400;
  localparam int SettleCyc  = 40;

  localparam logic [pwd_pkg::CoordW-1:0] CMax = 24'h7FFFFF;
  localparam logic [pwd_pkg::CoordW-1:0] CMin = 24'h800000;

  typedef struct packed {
    logic [24:0] distance;
    logic [2:0]  new_idx;
    logic [2:0]  old_idx;
    logic        last_in_run;
    logic        ovf;
  } dist_result_t;

  typedef struct packed {
    logic                       first_pt;
    logic [pwd_pkg::CoordW-1:0] x;
    logic [pwd_pkg::CoordW-1:0] y;
    logic [pwd_pkg::CoordW-1:0] z;
    logic                       typed;
    dist_result_t               res;
  } point_row_t;

  localparam dist_result_t NoRes = '0;

  // rows with typed set carry exactly one result, written out by hand
  point_row_t point_rows [0:15] = '{
    '{1'b1, 24'd0, 24'd0, 24'd0, 1'b0, NoRes},
    '{1'b0, CMax, 24'd0, 24'd0, 1'b1, '{25'd8388607, 3'd1, 3'd0, 1'b1, 1'b0}},
    '{1'b0, CMin, CMin, CMin, 1'b0, NoRes},
    '{1'b0, CMax, CMax, CMax, 1'b0, NoRes},
    '{1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, NoRes},
    '{1'b0, 24'd1, 24'd2, 24'd2, 1'b0, NoRes},
    '{1'b0, 24'h000FFF, 24'hFFF000, 24'h555555, 1'b0, NoRes},
    '{1'b0, 24'hAAAAAA, 24'h123456, 24'hEDCBA9, 1'b0, NoRes},
    '{1'b0, 24'd5, 24'd5, 24'd5, 1'b1, '{25'd0, 3'd0, 3'd0, 1'b1, 1'b1}},
    '{1'b0, CMax, CMax, CMax, 1'b1, '{25'd0, 3'd0, 3'd0, 1'b1, 1'b1}},
    '{1'b1, CMax, 24'd0, 24'd0, 1'b0, NoRes},
    '{1'b0, CMin, 24'd0, 24'd0, 1'b1, '{25'd16777215, 3'd1, 3'd0, 1'b1, 1'b0}},
    '{1'b1, 24'd3, 24'd4, 24'd0, 1'b0, NoRes},
    '{1'b0, 24'd0, 24'd0, 24'd0, 1'b1, '{25'd5, 3'd1, 3'd0, 1'b1, 1'b0}},
    '{1'b0, 24'd0, 24'd0, 24'd12, 1'b0, NoRes},
    '{1'b0, CMax, CMin, 24'd0, 1'b0, NoRes}
  };

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [pwd_pkg::InDataW-1:0]  s_tdata = '0;
  logic                         s_tuser = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [pwd_pkg::OutDataW-1:0] m_tdata;
  logic                         m_tlast;
  logic                         m_tuser;

  pairwise_distance_stream u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // local copy of the point store
  logic signed [pwd_pkg::CoordW-1:0] store_x [StoreDepth];
  logic signed [pwd_pkg::CoordW-1:0] store_y [StoreDepth];
  logic signed [pwd_pkg::CoordW-1:0] store_z [StoreDepth];
  int unsigned stored_points = 0;

  dist_result_t pending_distances [$];
  int fail_count = 0;
  int points_sent = 0;
  int hold_asks = 0;
  int holds_done = 0;
  int unsigned cycle_count = 0;

  function automatic logic [24:0] floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int b = 24; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) begin
        r = c;
      end
    end
    return r[24:0];
  endfunction

  function automatic longint unsigned sq_gap(input logic signed [pwd_pkg::CoordW-1:0] a,
                                             input logic signed [pwd_pkg::CoordW-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return longint'(d * d);
  endfunction

  // store the point and queue the distances it causes; keep=0 updates only
  task automatic store_point(input logic first_pt,
                             input logic [pwd_pkg::CoordW-1:0] x,
                             input logic [pwd_pkg::CoordW-1:0] y,
                             input logic [pwd_pkg::CoordW-1:0] z,
                             input bit keep);
    dist_result_t r;
    longint unsigned sum;
    int unsigned n;
    if (first_pt) begin
      stored_points = 0;
    end
    if (stored_points >= StoreDepth) begin
      r = '{25'd0, 3'd0, 3'd0, 1'b1, 1'b1};
      if (keep) begin
        pending_distances.push_back(r);
      end
      return;
    end
    n = stored_points;
    store_x[n] = x;
    store_y[n] = y;
    store_z[n] = z;
    for (int unsigned j = 0; j < n; j++) begin
      sum = sq_gap(x, store_x[j]) + sq_gap(y, store_y[j]) + sq_gap(z, store_z[j]);
      r.distance    = floor_root(sum);
      r.new_idx     = n[2:0];
      r.old_idx     = j[2:0];
      r.last_in_run = (j + 1 == n);
      r.ovf         = 1'b0;
      if (keep) begin
        pending_distances.push_back(r);
      end
    end
    stored_points = n + 1;
  endtask

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) begin
      return 0;
    end else if (k < 88) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(12, 45);
  endfunction

  // sits at a rising edge on entry and on return; item is taken on return
  task automatic send_point(input logic first_pt,
                            input logic [pwd_pkg::CoordW-1:0] x,
                            input logic [pwd_pkg::CoordW-1:0] y,
                            input logic [pwd_pkg::CoordW-1:0] z,
                            input bit typed, input dist_result_t typed_res);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= first_pt;
    s_tdata  <= {z, y, x};
    do begin
      @(posedge clk);
    end while (!s_tready);
    store_point(first_pt, x, y, z, !typed);
    if (typed) begin
      pending_distances.push_back(typed_res);
    end
    points_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= pwd_pkg::InDataW'({$urandom, $urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_distances.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [pwd_pkg::CoordW-1:0] rand_coord(
      input logic [pwd_pkg::CoordW-1:0] center);
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: begin
        return CMax;
      end
      1: begin
        return CMin;
      end
      2: begin
        return ($urandom_range(0, 1) != 0) ? '0 : '1;
      end
      3, 4, 5: begin
        return pwd_pkg::CoordW'($urandom);
      end
      default: begin
        return center + pwd_pkg::CoordW'($urandom_range(0, 8191) - 4096);
      end
    endcase
  endfunction

  // sender
  initial begin
    int set_len;
    int k;
    logic [pwd_pkg::CoordW-1:0] cx;
    logic [pwd_pkg::CoordW-1:0] cy;
    logic [pwd_pkg::CoordW-1:0] cz;
    bit drained_mid;
    drained_mid = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (point_rows[i]) begin
      send_point(point_rows[i].first_pt, point_rows[i].x, point_rows[i].y,
                 point_rows[i].z, point_rows[i].typed, point_rows[i].res);
    end
    drain_results();
    while (points_sent < PointItems) begin
      k = $urandom_range(0, 99);
      cx = pwd_pkg::CoordW'($urandom);
      cy = pwd_pkg::CoordW'($urandom);
      cz = pwd_pkg::CoordW'($urandom);
      if (k < 12) begin
        // stray point, may continue or restart whatever set is open
        send_point(1'($urandom_range(0, 1)), rand_coord(cx), rand_coord(cy),
                   rand_coord(cz), 1'b0, NoRes);
      end else begin
        k = $urandom_range(0, 99);
        if (k < 8) begin
          set_len = $urandom_range(StoreDepth + 1, StoreDepth + 3);
        end else if (k < 20) begin
          set_len = $urandom_range(1, 2);
        end else begin
          set_len = $urandom_range(3, StoreDepth);
        end
        for (int p = 0; p < set_len; p++) begin
          send_point(p == 0, rand_coord(cx), rand_coord(cy), rand_coord(cz), 1'b0, NoRes);
        end
      end
      if ((points_sent >= 160 && hold_asks == 0) || (points_sent >= 360 && hold_asks == 1)) begin
        hold_asks++;
      end
      if (points_sent >= 300 && !drained_mid) begin
        drained_mid = 1;
        drain_results();
      end
    end
    drain_results();
    repeat (SettleCyc) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int lo;
    int hi;
    int k;
    @(negedge rst);
    forever begin
      if (hold_asks != holds_done) begin
        repeat (LongHold) @(posedge clk) m_tready <= 1'b0;
        holds_done++;
      end
      k = $urandom_range(0, 99);
      if (k < 60) begin
        lo = 0;
      end else if (k < 90) begin
        lo = $urandom_range(1, 3);
      end else begin
        lo = $urandom_range(15, 50);
      end
      hi = $urandom_range(1, 24);
      repeat (lo) @(posedge clk) m_tready <= 1'b0;
      repeat (hi) @(posedge clk) m_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    dist_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_distances.size() == 0) begin
        $display("%0t: unexpected item tdata=%h tlast=%b tuser=%b",
                 $time, m_tdata, m_tlast, m_tuser);
        fail_count++;
      end else begin
        want = pending_distances.pop_front();
        if (m_tdata[24:0] !== want.distance) begin
          $display("%0t: distance expected %0d got %0d", $time, want.distance,
                   m_tdata[24:0]);
          fail_count++;
        end
        if (m_tdata[27:25] !== want.new_idx) begin
          $display("%0t: new_index expected %0d got %0d", $time, want.new_idx,
                   m_tdata[27:25]);
          fail_count++;
        end
        if (m_tdata[30:28] !== want.old_idx) begin
          $display("%0t: old_index expected %0d got %0d", $time, want.old_idx,
                   m_tdata[30:28]);
          fail_count++;
        end
        if (m_tlast !== want.last_in_run) begin
          $display("%0t: last_in_run expected %b got %b", $time, want.last_in_run, m_tlast);
          fail_count++;
        end
        if (m_tuser !== want.ovf) begin
          $display("%0t: overflow expected %b got %b", $time, want.ovf, m_tuser);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d items still pending", $time, pending_distances.size());
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

/* pairwise_distance_stream.f */
rtl/pwd_pkg.sv
rtl/pwd_ram.sv
rtl/pwd_isqrt.sv
rtl/pairwise_distance_stream.sv
test/pairwise_distance_stream_test.sv
